// ----- hdl/shs_pkg.sv -----
// shared types, constants and tables for the sine harmonic shaper
`timescale 1ns / 1ps
package shs_pkg;

    localparam int IN_GAIN_W  = 19;
    localparam int STAGE_W    = 4;
    localparam int SLEW_W     = 14;
    localparam int OUT_GAIN_W = 18;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_SCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd3;

    localparam logic [IN_GAIN_W-1:0]  RST_INPUT_GAIN  = 19'd65536;
    localparam logic [STAGE_W-1:0]    RST_STAGE_COUNT = 4'd2;
    localparam logic [SLEW_W-1:0]     RST_SLEW_SCALE  = 14'd4915;
    localparam logic [OUT_GAIN_W-1:0] RST_OUTPUT_GAIN = 18'd44564;

    localparam int OUT_W     = 28;
    localparam int STATE_W   = 26;
    localparam int Y_W       = 27;
    localparam int SINE_W    = 26;
    localparam int ARG_W     = 32;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 38;
    localparam int DIV_Q_W   = 22;

    localparam logic [31:0] TURN_K     = 32'd1367130551;
    localparam logic [31:0] PIHALF_Q30 = 32'd1686629713;
    localparam int          HORNER_STEPS = 5;

    typedef struct packed {
        logic [IN_GAIN_W-1:0]  input_gain;
        logic [STAGE_W-1:0]    stage_count;
        logic [SLEW_W-1:0]     slew_scale;
        logic [OUT_GAIN_W-1:0] output_gain;
    } shs_cfg_t;

    // taylor divisors, highest order first
    function automatic logic [6:0] horner_div(input logic [2:0] step);
        logic [6:0] d;
        unique case (step)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] horner_recip(input logic [2:0] step);
        logic [31:0] r;
        unique case (step)
            3'd0:    r = 32'd39045157;
            3'd1:    r = 32'd59652323;
            3'd2:    r = 32'd102261126;
            3'd3:    r = 32'd214748364;
            default: r = 32'd715827882;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/shs_if.sv -----
// stream and configuration channel interfaces
`timescale 1ns / 1ps
interface shs_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface shs_out_if import shs_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface shs_cfg_if import shs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/shs_div.sv -----
// serial restoring divider for the rounded stage term
`timescale 1ns / 1ps
module shs_div import shs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_Q_W-1:0]   quot
);

    localparam int SH_W  = DIV_DEN_W + DIV_Q_W;
    localparam int CNT_W = $clog2(DIV_Q_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] rem_reg;
    logic [SH_W-1:0]      dsh_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic                 fits;

    assign fits = SH_W'(rem_reg) >= dsh_reg;
    assign busy = busy_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_Q_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, {DIV_Q_W-1{1'b0}}, 1'b0} >> 1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg[DIV_NUM_W-1:0];
            end
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

// ----- hdl/shs_sine.sv -----
// multi-cycle fixed point sine on one shared multiplier
`timescale 1ns / 1ps
module shs_sine import shs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ARG_W-1:0]  arg,
    output logic                     busy,
    output logic signed [SINE_W-1:0] sine
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FOLD  = 4'd1;
    localparam logic [3:0] S_TMUL  = 4'd2;
    localparam logic [3:0] S_T2MUL = 4'd3;
    localparam logic [3:0] S_HINIT = 4'd4;
    localparam logic [3:0] S_HP    = 4'd5;
    localparam logic [3:0] S_HQ    = 4'd6;
    localparam logic [3:0] S_HC    = 4'd7;
    localparam logic [3:0] S_SM    = 4'd8;
    localparam logic [3:0] S_SV    = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [63:0] prod_reg;
    logic [31:0] mul_a, mul_b;
    logic [31:0] arg_mag;
    logic        neg_reg;
    logic [1:0]  quad_reg;
    logic [30:0] f_reg, t_reg, r_reg;
    logic [31:0] t2_reg, p_reg;
    logic [2:0]  step_reg;
    logic signed [SINE_W-1:0] sine_reg;

    logic [31:0] ph, phs;
    logic [31:0] q0, qc;
    logic [38:0] qd, rem;
    logic [6:0]  dv;
    logic [31:0] vs;
    logic [24:0] v;

    assign arg_mag = arg[ARG_W-1] ? 32'(-arg) : 32'(arg);
    assign ph  = prod_reg[55:24];
    assign phs = neg_reg ? (32'd0 - ph) : ph;
    assign dv  = horner_div(step_reg);
    assign q0  = prod_reg[63:32];
    assign qd  = 39'(q0) * 39'(dv);
    assign rem = 39'(p_reg) - qd;
    assign qc  = q0 + 32'(rem >= 39'(dv));
    assign vs  = 32'(prod_reg[60:30]) + 32'd64;
    assign v   = vs[31:7];

    assign busy = state_reg != S_IDLE;
    assign sine = sine_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                mul_a = arg_mag;
                mul_b = TURN_K;
            end
            S_TMUL:
            begin
                mul_a = 32'(f_reg);
                mul_b = PIHALF_Q30;
            end
            S_T2MUL:
            begin
                mul_a = 32'(prod_reg[60:30]);
                mul_b = 32'(prod_reg[60:30]);
            end
            S_HP:
            begin
                mul_a = t2_reg;
                mul_b = 32'(r_reg);
            end
            S_HQ:
            begin
                mul_a = prod_reg[61:30];
                mul_b = horner_recip(step_reg);
            end
            S_SM:
            begin
                mul_a = 32'(t_reg);
                mul_b = 32'(r_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = start ? S_FOLD : S_IDLE;
            S_FOLD:  state_next = S_TMUL;
            S_TMUL:  state_next = S_T2MUL;
            S_T2MUL: state_next = S_HINIT;
            S_HINIT: state_next = S_HP;
            S_HP:    state_next = S_HQ;
            S_HQ:    state_next = S_HC;
            S_HC:    state_next = (step_reg == 3'(HORNER_STEPS - 1)) ? S_SM : S_HP;
            S_SM:    state_next = S_SV;
            S_SV:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            S_IDLE:
            begin
                neg_reg <= arg[ARG_W-1];
            end
            S_FOLD:
            begin
                quad_reg <= phs[31:30];
                f_reg    <= phs[30] ? (31'h4000_0000 - 31'(phs[29:0])) : 31'(phs[29:0]);
            end
            S_T2MUL:
            begin
                t_reg <= prod_reg[60:30];
            end
            S_HINIT:
            begin
                t2_reg   <= prod_reg[61:30];
                r_reg    <= 31'h4000_0000;
                step_reg <= '0;
            end
            S_HQ:
            begin
                p_reg <= prod_reg[61:30];
            end
            S_HC:
            begin
                r_reg    <= 31'h4000_0000 - 31'(qc);
                step_reg <= step_reg + 1'b1;
            end
            S_SV:
            begin
                sine_reg <= quad_reg[1] ? -$signed(SINE_W'(v)) : $signed(SINE_W'(v));
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/shs_lane.sv -----
// one channel: gain, sine shaping, slew-gated harmonic stages, output gain
`timescale 1ns / 1ps
module shs_lane import shs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_STAGES  = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  shs_cfg_t                      cfg,
    output logic                          done,
    output logic signed [OUT_W-1:0]       result
);

    localparam int KW = $clog2(MAX_STAGES + 1);

    localparam logic [4:0] L_IDLE = 5'd0;
    localparam logic [4:0] L_GRND = 5'd1;
    localparam logic [4:0] L_S1   = 5'd2;
    localparam logic [4:0] L_W1   = 5'd3;
    localparam logic [4:0] L_S2   = 5'd4;
    localparam logic [4:0] L_W2   = 5'd5;
    localparam logic [4:0] L_CHK  = 5'd6;
    localparam logic [4:0] L_KY   = 5'd7;
    localparam logic [4:0] L_KA   = 5'd8;
    localparam logic [4:0] L_KS   = 5'd9;
    localparam logic [4:0] L_MR   = 5'd10;
    localparam logic [4:0] L_SW   = 5'd11;
    localparam logic [4:0] L_DS   = 5'd12;
    localparam logic [4:0] L_DW   = 5'd13;
    localparam logic [4:0] L_FIN  = 5'd14;
    localparam logic [4:0] L_OM   = 5'd15;
    localparam logic [4:0] L_OR   = 5'd16;

    localparam logic signed [Y_W-1:0] Y_HI = Y_W'((2 ** (STATE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0] Y_LO = -Y_W'(2 ** (STATE_W - 1));
    localparam logic [63:0] OUT_HI = 64'((2 ** (OUT_W - 1)) - 1);
    localparam logic [63:0] OUT_NEG_LIM = 64'(2 ** (OUT_W - 1));

    logic [4:0]  state_reg, state_next;
    logic [63:0] lprod_reg;
    logic [31:0] lmul_a, lmul_b;

    logic                       sneg_reg, yneg_reg, tneg_reg;
    logic signed [ARG_W-1:0]    arg_reg;
    logic signed [Y_W-1:0]      y_reg;
    logic signed [STATE_W-1:0]  prev_reg;
    logic [KW-1:0]              k_reg;
    logic [9:0]                 k2_reg;
    logic [14:0]                k3_reg;
    logic [Y_W-1:0]             dabs_reg;
    logic [23:0]                w_reg;
    logic signed [OUT_W-1:0]    result_reg;
    logic                       done_reg;

    logic                       sine_start, sine_busy;
    logic signed [SINE_W-1:0]   sine_val;
    logic [SINE_W-1:0]          sine_mag;
    logic                       div_start, div_busy;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DIV_DEN_W-1:0]       div_den;
    logic [DIV_Q_W-1:0]         div_q;

    logic [SAMPLE_BITS-1:0]     smag;
    logic [Y_W-1:0]             ymag;
    logic [STATE_W-1:0]         pmag;
    logic [63:0]                xsum, msum, osum;
    logic signed [ARG_W-1:0]    xm, kp;
    logic [SINE_W:0]            hsum;
    logic signed [Y_W-1:0]      hval, half, tval, term;
    logic signed [Y_W:0]        diff;
    logic [Y_W-1:0]             dmag;
    logic signed [STATE_W-1:0]  yc;
    logic                       more;

    shs_sine u_sine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sine_start),
        .arg   (arg_reg),
        .busy  (sine_busy),
        .sine  (sine_val)
    );

    shs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    assign sine_start = (state_reg == L_S1) || (state_reg == L_S2) || (state_reg == L_KS);
    assign div_start  = state_reg == L_DS;
    assign div_num    = lprod_reg[DIV_NUM_W-1:0] + (DIV_NUM_W'(k3_reg) << 22);
    assign div_den    = DIV_DEN_W'(k3_reg) << 23;

    assign smag     = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    assign ymag     = y_reg[Y_W-1] ? Y_W'(-y_reg) : Y_W'(y_reg);
    assign pmag     = prev_reg[STATE_W-1] ? STATE_W'(-prev_reg) : STATE_W'(prev_reg);
    assign sine_mag = sine_val[SINE_W-1] ? SINE_W'(-sine_val) : SINE_W'(sine_val);

    // input gain, rounded half away from zero back to q.23
    assign xsum = lprod_reg + (64'd1 << (SAMPLE_BITS - 9));
    assign xm   = $signed(ARG_W'(xsum >> (SAMPLE_BITS - 8)));

    assign hsum = {1'b0, sine_mag} + 1'b1;
    assign hval = $signed(Y_W'(hsum[SINE_W:1]));
    assign half = sine_val[SINE_W-1] ? -hval : hval;

    assign diff = (Y_W+1)'(y_reg) - (Y_W+1)'(prev_reg);
    assign dmag = diff[Y_W] ? Y_W'(-diff) : Y_W'(diff);
    assign kp   = $signed(lprod_reg[ARG_W-1:0]);
    assign msum = (lprod_reg + 64'd32768) >> 16;
    assign tval = $signed(Y_W'(div_q));
    assign term = tneg_reg ? -tval : tval;
    assign osum = (lprod_reg + 64'd32768) >> 16;

    assign yc = (y_reg > Y_HI) ? STATE_W'(Y_HI) :
                (y_reg < Y_LO) ? STATE_W'(Y_LO) : STATE_W'(y_reg);

    assign more = (32'(k_reg) < 32'(cfg.stage_count)) && (32'(k_reg) < MAX_STAGES);

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        lmul_a = '0;
        lmul_b = '0;
        unique case (state_reg)
            L_IDLE:
            begin
                lmul_a = 32'(smag);
                lmul_b = 32'(cfg.input_gain);
            end
            L_KY:
            begin
                lmul_a = 32'(ymag);
                lmul_b = 32'(k_reg);
            end
            L_KA:
            begin
                lmul_a = 32'(k2_reg);
                lmul_b = 32'(cfg.slew_scale);
            end
            L_KS:
            begin
                lmul_a = 32'(dabs_reg);
                lmul_b = lprod_reg[31:0];
            end
            L_SW:
            begin
                lmul_a = 32'(sine_mag);
                lmul_b = 32'(w_reg);
            end
            L_OM:
            begin
                lmul_a = 32'(pmag);
                lmul_b = 32'(cfg.output_gain);
            end
            default:
            begin
                lmul_a = '0;
                lmul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:  state_next = start ? L_GRND : L_IDLE;
            L_GRND:  state_next = L_S1;
            L_S1:    state_next = L_W1;
            L_W1:    state_next = sine_busy ? L_W1 : L_S2;
            L_S2:    state_next = L_W2;
            L_W2:    state_next = sine_busy ? L_W2 : L_CHK;
            L_CHK:   state_next = more ? L_KY : L_FIN;
            L_KY:    state_next = L_KA;
            L_KA:    state_next = L_KS;
            L_KS:    state_next = L_MR;
            L_MR:    state_next = L_SW;
            L_SW:    state_next = sine_busy ? L_SW : L_DS;
            L_DS:    state_next = L_DW;
            L_DW:    state_next = div_busy ? L_DW : L_CHK;
            L_FIN:   state_next = L_OM;
            L_OM:    state_next = L_OR;
            L_OR:    state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == L_OR;
            if (state_reg == L_FIN)
            begin
                prev_reg <= yc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lprod_reg <= 64'(lmul_a) * 64'(lmul_b);
        case (state_reg)
            L_IDLE:
            begin
                sneg_reg <= sample[SAMPLE_BITS-1];
            end
            L_GRND:
            begin
                arg_reg <= sneg_reg ? -xm : xm;
            end
            L_W1:
            begin
                y_reg   <= Y_W'(sine_val);
                arg_reg <= ARG_W'(sine_val) <<< 1;
            end
            L_W2:
            begin
                // add the half term once the second sine is ready
                if (!sine_busy)
                begin
                    y_reg <= y_reg + half;
                end
                k_reg <= KW'(2);
            end
            L_KY:
            begin
                k2_reg   <= 10'(k_reg * k_reg);
                dabs_reg <= dmag;
                yneg_reg <= y_reg[Y_W-1];
            end
            L_KA:
            begin
                arg_reg <= yneg_reg ? -kp : kp;
                k3_reg  <= 15'(k2_reg * k_reg);
            end
            L_MR:
            begin
                // gate weight, zero once the slew term reaches unity
                w_reg <= (msum >= 64'h80_0000) ? 24'd0 : 24'(64'h80_0000 - msum);
            end
            L_SW:
            begin
                tneg_reg <= sine_val[SINE_W-1];
            end
            L_DW:
            begin
                if (!div_busy)
                begin
                    y_reg <= y_reg + term;
                    k_reg <= k_reg + 1'b1;
                end
            end
            L_OR:
            begin
                if (!prev_reg[STATE_W-1])
                begin
                    result_reg <= (osum > OUT_HI) ? OUT_W'(OUT_HI) : OUT_W'(osum);
                end
                else
                begin
                    result_reg <= (osum > OUT_NEG_LIM) ? -OUT_W'(OUT_NEG_LIM)
                                                       : -OUT_W'(osum);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/slew_aware_sine_harmonic_shaper_core.sv -----
// top level: configuration registers, two channel lanes and the output merge
`timescale 1ns / 1ps
// Stereo sine waveshaper. Each accepted word carries a left and right sample;
// both channels run side by side in their own lane (gain, sin(x), the sin(2y)/2
// term, then the slew-gated harmonic stages) and a merge stage pairs the two
// results into one output word. The number of harmonic stages per item is
// min(stage_count, MAX_STAGES) - 2 and never below zero; each stage runs the
// per-lane sine sequencer (on one shared multiplier) and then the 22-step
// serial divider that forms the stage term. One item is in flight at a time;
// the next word is taken once both lane results have moved into the output
// register, so a result that is held by a stalled receiver also holds off the
// input.
// Configuration writes are always ready and must only be issued while no item
// is in flight.
module slew_aware_sine_harmonic_shaper_core import shs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_STAGES  = 14
)
(
    input  logic       clk,
    input  logic       rst_n,
    shs_in_if.sink     samples,
    shs_out_if.source  results,
    shs_cfg_if.sink    cfg
);

    shs_cfg_t cfg_reg;

    logic busy_reg;
    logic l_flag_reg, r_flag_reg;
    logic out_valid_reg;
    logic signed [OUT_W-1:0] left_out_reg, right_out_reg;

    logic accept;
    logic merge;
    logic l_done, r_done;
    logic signed [OUT_W-1:0] l_result, r_result;

    // new word only when no item is in flight
    assign samples.ready = !busy_reg;
    assign accept        = samples.valid && samples.ready;

    // both lanes finished and the output register is free or draining
    assign merge = l_flag_reg && r_flag_reg && (!out_valid_reg || results.ready);

    assign results.valid     = out_valid_reg;
    assign results.left_out  = left_out_reg;
    assign results.right_out = right_out_reg;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_gain  <= RST_INPUT_GAIN;
            cfg_reg.stage_count <= RST_STAGE_COUNT;
            cfg_reg.slew_scale  <= RST_SLEW_SCALE;
            cfg_reg.output_gain <= RST_OUTPUT_GAIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_INPUT_GAIN:  cfg_reg.input_gain  <= IN_GAIN_W'(cfg.data);
                REG_STAGE_COUNT: cfg_reg.stage_count <= STAGE_W'(cfg.data);
                REG_SLEW_SCALE:  cfg_reg.slew_scale  <= SLEW_W'(cfg.data);
                REG_OUTPUT_GAIN: cfg_reg.output_gain <= OUT_GAIN_W'(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    // left lane
    shs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_STAGES  (MAX_STAGES)
    ) u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (samples.left_sample),
        .cfg    (cfg_reg),
        .done   (l_done),
        .result (l_result)
    );

    // right lane
    shs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_STAGES  (MAX_STAGES)
    ) u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (samples.right_sample),
        .cfg    (cfg_reg),
        .done   (r_done),
        .result (r_result)
    );

    // merge control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            l_flag_reg    <= 1'b0;
            r_flag_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (merge)
            begin
                busy_reg <= 1'b0;
            end

            if (merge)
            begin
                l_flag_reg <= 1'b0;
                r_flag_reg <= 1'b0;
            end
            else
            begin
                l_flag_reg <= l_flag_reg || l_done;
                r_flag_reg <= r_flag_reg || r_done;
            end

            if (merge)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (merge)
        begin
            left_out_reg  <= l_result;
            right_out_reg <= r_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("item accepted but block not marked busy");

    a_merge_busy : assert property (@(posedge clk) disable iff (!rst_n)
        merge |-> busy_reg)
        else $error("merge without an item in flight");

    a_left_once : assert property (@(posedge clk) disable iff (!rst_n)
        l_done |-> (busy_reg && !l_flag_reg))
        else $error("left lane finished twice or while idle");

    a_right_once : assert property (@(posedge clk) disable iff (!rst_n)
        r_done |-> (busy_reg && !r_flag_reg))
        else $error("right lane finished twice or while idle");
`endif

endmodule

// ----- bench/slew_aware_sine_harmonic_shaper_core_tb.sv -----
// self-checking bench for the sine harmonic shaper core
`timescale 1ns / 1ps
module slew_aware_sine_harmonic_shaper_core_tb;
    import shs_pkg::*;

    localparam int SB = 24;
    localparam int MAXS = 14;
    // bound for the worst item (12 harmonic stages), with margin
    localparam int ITEM_CYCLES = 700;

    typedef struct packed {
        logic signed [SB-1:0] left_sample;
        logic signed [SB-1:0] right_sample;
    } pair_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
    } shaped_t;

    logic clk;
    logic rst_n;

    shs_in_if #(.SAMPLE_BITS(SB)) samples_ch ();
    shs_out_if results_ch ();
    shs_cfg_if cfg_ch ();

    slew_aware_sine_harmonic_shaper_core #(.SAMPLE_BITS(SB), .MAX_STAGES(MAXS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch.sink),
        .results(results_ch.source),
        .cfg(cfg_ch.sink)
    );

    // predictor copy of the registers and the per-channel history
    logic [IN_GAIN_W-1:0]  gain_in;
    logic [STAGE_W-1:0]    stages;
    logic [SLEW_W-1:0]     slew;
    logic [OUT_GAIN_W-1:0] gain_out;
    longint prev_l, prev_r;

    pair_t   pending_pairs[$];
    shaped_t expected_shaped[$];
    int      failures;
    int      in_gap;        // cycles of sender idling left
    int      out_stall;     // cycles of receiver stall left
    bit      bursts_on;     // sender idling and receiver stalls allowed
    bit      sender_hold;   // hold sender until drained

    function automatic longint round_div(longint num, longint den);
        longint q;
        if (num < 0)
        begin
            q = (-num + den / 2) / den;
            return -q;
        end
        q = (num + den / 2) / den;
        return q;
    endfunction

    function automatic longint clip(longint v, longint hi);
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // q.23 sine via quarter-wave folded taylor series
    function automatic longint sine23(longint x);
        bit neg;
        logic [63:0] mag, f, t, t2, r, s, prod;
        logic [31:0] ph;
        logic [1:0]  quad;
        longint v;
        neg  = x < 0;
        mag  = neg ? 64'(-x) : 64'(x);
        prod = mag * 64'(TURN_K);
        ph   = prod[55:24];
        if (neg)
            ph = -ph;
        quad = ph[31:30];
        f    = {34'd0, ph[29:0]};
        if (quad[0])
            f = (64'd1 << 30) - f;
        t  = (f * 64'(PIHALF_Q30)) >> 30;
        t2 = (t * t) >> 30;
        r  = 64'd1 << 30;
        r  = (64'd1 << 30) - ((t2 * r) >> 30) / 110;
        r  = (64'd1 << 30) - ((t2 * r) >> 30) / 72;
        r  = (64'd1 << 30) - ((t2 * r) >> 30) / 42;
        r  = (64'd1 << 30) - ((t2 * r) >> 30) / 20;
        r  = (64'd1 << 30) - ((t2 * r) >> 30) / 6;
        s  = (t * r) >> 30;
        v  = longint'((s + 64) >> 7);
        return quad[1] ? -v : v;
    endfunction

    function automatic longint shape_lane(longint smp, ref longint hist);
        longint x, y, d, m, w, lim;
        x = round_div(smp * longint'(gain_in), longint'(1) << (SB - 8));
        y = sine23(x);
        lim = longint'(stages);
        if (lim > MAXS)
            lim = MAXS;
        y += round_div(sine23(2 * y), 2);
        for (longint k = 2; k < lim; k++)
        begin
            d = y - hist;
            if (d < 0)
                d = -d;
            m = round_div(d * longint'(slew) * k * k, longint'(1) << 16);
            w = (longint'(1) << 23) - m;
            if (w < 0)
                w = 0;
            y += round_div(sine23(k * y) * w, k * k * k * (longint'(1) << 23));
        end
        y = clip(y, (longint'(1) << 25) - 1);
        hist = y;
        return clip(round_div(y * longint'(gain_out), longint'(1) << 16),
                    (longint'(1) << 27) - 1);
    endfunction

    function automatic shaped_t predict_shaped(pair_t p);
        shaped_t e;
        e.left_out  = OUT_W'(shape_lane(longint'(p.left_sample), prev_l));
        e.right_out = OUT_W'(shape_lane(longint'(p.right_sample), prev_r));
        return e;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: sender side with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
            samples_ch.left_sample <= '0;
            samples_ch.right_sample <= '0;
            in_gap <= 0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                expected_shaped.push_back(predict_shaped({samples_ch.left_sample,
                                                          samples_ch.right_sample}));
            end
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    samples_ch.valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0 && !sender_hold)
                begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    samples_ch.valid <= 1'b1;
                    samples_ch.left_sample <= p.left_sample;
                    samples_ch.right_sample <= p.right_sample;
                    if (bursts_on && $urandom_range(0, 9) == 0)
                        in_gap <= $urandom_range(1, 14);
                end
                else
                    samples_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: receiver stalls and field checks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_shaped.size() == 0)
                begin
                    $error("unexpected word left_out=%0d right_out=%0d",
                           results_ch.left_out, results_ch.right_out);
                    failures++;
                end
                else
                begin
                    shaped_t e;
                    e = expected_shaped.pop_front();
                    if (e.left_out !== results_ch.left_out)
                    begin
                        $error("left_out expected %0d actual %0d", e.left_out,
                               results_ch.left_out);
                        failures++;
                    end
                    if (e.right_out !== results_ch.right_out)
                    begin
                        $error("right_out expected %0d actual %0d", e.right_out,
                               results_ch.right_out);
                        failures++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                results_ch.ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= $urandom_range(1, 14);
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_INPUT_GAIN:  gain_in  = val[IN_GAIN_W-1:0];
            REG_STAGE_COUNT: stages   = val[STAGE_W-1:0];
            REG_SLEW_SCALE:  slew     = val[SLEW_W-1:0];
            default:         gain_out = val[OUT_GAIN_W-1:0];
        endcase
    endtask

    task automatic set_all(input logic [CFG_DATA_W-1:0] ig, input logic [CFG_DATA_W-1:0] sc,
                           input logic [CFG_DATA_W-1:0] sl, input logic [CFG_DATA_W-1:0] og);
        write_reg(REG_INPUT_GAIN, ig);
        write_reg(REG_STAGE_COUNT, sc);
        write_reg(REG_SLEW_SCALE, sl);
        write_reg(REG_OUTPUT_GAIN, og);
    endtask

    // wait until everything queued has come back, then let the core settle
    task automatic drain();
        while (pending_pairs.size() > 0 || samples_ch.valid || expected_shaped.size() > 0)
            @(posedge clk);
        repeat (ITEM_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SB-1){1'b1}}};
            1: return {1'b1, {(SB-1){1'b0}}};
            2: return SB'($urandom_range(0, 4000)) - SB'(2000);
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        pair_t p;
        for (int i = 0; i < n; i++)
        begin
            p.left_sample  = rand_sample();
            p.right_sample = rand_sample();
            pending_pairs.push_back(p);
        end
    endtask

    initial
    begin
        pair_t p;
        failures = 0;
        bursts_on = 1'b1;
        sender_hold = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        gain_in = RST_INPUT_GAIN;
        stages = RST_STAGE_COUNT;
        slew = RST_SLEW_SCALE;
        gain_out = RST_OUTPUT_GAIN;
        prev_l = 0;
        prev_r = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes at reset settings, no harmonic stages
        p = '{{1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}}; pending_pairs.push_back(p);
        p = '{'0, '0}; pending_pairs.push_back(p);
        p = '{'1, SB'(1)}; pending_pairs.push_back(p);
        p = '{{1'b1, {(SB-1){1'b0}}}, {1'b0, {(SB-1){1'b1}}}}; pending_pairs.push_back(p);
        drain();

        // max gains, stage count past the limit, max slew field
        set_all(19'h7FFFF, 19'd15, 19'h3FFF, 19'h3FFFF);
        p = '{{1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}}; pending_pairs.push_back(p);
        p = '{SB'(1), '1}; pending_pairs.push_back(p);
        p = '{SB'(12345), -SB'(12345)}; pending_pairs.push_back(p);
        drain();

        // zero gains and slew, stage count zero and three
        set_all(19'd0, 19'd0, 19'd0, 19'd0);
        p = '{SB'(4000000), -SB'(4000000)}; pending_pairs.push_back(p);
        drain();
        set_all(19'd65536, 19'd3, 19'd0, 19'd178258);
        p = '{SB'(4000000), -SB'(4000000)}; pending_pairs.push_back(p);
        p = '{SB'(-1), SB'(2)}; pending_pairs.push_back(p);
        drain();

        // random phases across settings; each phase drains before reconfig
        for (int ph = 0; ph < 12; ph++)
        begin
            set_all(ph == 0 ? 19'd262144 : 19'($urandom_range(0, 262144)),
                    ph == 1 ? 19'd14 : 19'($urandom_range(0, 15)),
                    ph == 2 ? 19'd9830 : 19'($urandom_range(0, 16383)),
                    ph == 3 ? 19'd178258 : 19'($urandom_range(0, 262143)));
            if (ph == 11)
                bursts_on = 1'b0;
            queue_random(75);
            if (ph == 5)
            begin
                // hold the sender until every result is back
                while (pending_pairs.size() > 40) @(posedge clk);
                sender_hold = 1'b1;
                while (samples_ch.valid || expected_shaped.size() > 0) @(posedge clk);
                sender_hold = 1'b0;
            end
            drain();
        end
        // long run at mid settings for the bulk of items
        set_all(19'd65536 + 19'($urandom_range(0, 65536)), 19'd6, 19'd4915, 19'd44564);
        bursts_on = 1'b1;
        queue_random(600);
        drain();
        set_all(19'd131072, 19'd2, 19'd2000, 19'd90000);
        queue_random(300);
        drain();
        bursts_on = 1'b0;
        set_all(19'd80000, 19'd8, 19'd9830, 19'd60000);
        queue_random(50);
        drain();

        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit: ~1900 items, each within ITEM_CYCLES plus stalls, several times over
    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/shs_pkg.sv
hdl/shs_if.sv
hdl/shs_div.sv
hdl/shs_sine.sv
hdl/shs_lane.sv
hdl/slew_aware_sine_harmonic_shaper_core.sv
bench/slew_aware_sine_harmonic_shaper_core_tb.sv
